// File: hw/rtl/primitive_root_finder_unit_macros.svh
// Assertion macros for the primitive root finder
`ifndef PRIMITIVE_ROOT_FINDER_UNIT_MACROS_SVH
`define PRIMITIVE_ROOT_FINDER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define PRF_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define PRF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define PRF_ASSERT_IMPL(label, clk, rst, ante, cons)
`define PRF_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: hw/rtl/prf_pkg.sv
`default_nettype none
package prf_pkg;
  localparam int WIDTH = 16;
  localparam int MAX_FACTORS = 6;
  localparam int FIDX_W = $clog2(MAX_FACTORS + 1);

  localparam logic [1:0] ST_FOUND = 2'd0;
  localparam logic [1:0] ST_NOT_PRIME = 2'd1;
  localparam logic [1:0] ST_NO_ROOT = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE, S_PCHK, S_PDIV, S_PDIV_W, S_PDIV2, S_PDIV2_W,
    S_FINIT, S_FSQ, S_FDIV, S_FDIV_W, S_FADD,
    S_RNEXT, S_ESTART, S_EDIV, S_EDIV_W, S_EMUL, S_EMUL_W, S_ECHK,
    S_OUT
  } state_t;

  // datapath commands
  typedef struct packed {
    logic load;        // capture modulus
    logic div_start;   // start divider
    logic [2:0] div_sel;
    logic [3:0] op;    // datapath step
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic small_n;     // n <= 3
    logic n_le1;
    logic rem_zero;
    logic sq_gt;       // trial^2 > value
    logic ex_zero;
    logic acc_one;
    logic r_over;      // r > phi
    logic f_last;      // factor index == count
    logic p_mod_zero;
    logic trial2;      // trial is 2 (prime and factor phases)
    logic ebit;
  } sts_t;

  // datapath ops
  localparam logic [3:0] OP_NONE = 4'd0;
  localparam logic [3:0] OP_PINIT = 4'd1;
  localparam logic [3:0] OP_PSTEP = 4'd2;
  localparam logic [3:0] OP_FINIT = 4'd3;
  localparam logic [3:0] OP_FDIVOK = 4'd4;
  localparam logic [3:0] OP_FNEXT = 4'd5;
  localparam logic [3:0] OP_FLAST = 4'd6;
  localparam logic [3:0] OP_RINIT = 4'd7;
  localparam logic [3:0] OP_RNEXT = 4'd8;
  localparam logic [3:0] OP_EINIT = 4'd9;
  localparam logic [3:0] OP_EACC = 4'd10;
  localparam logic [3:0] OP_EBASE = 4'd11;
  localparam logic [3:0] OP_FIDX = 4'd12;
  localparam logic [3:0] OP_PMARK = 4'd13;
  localparam logic [3:0] OP_ERED = 4'd14;

  // divider operand selects
  localparam logic [2:0] DS_N_T = 3'd0;
  localparam logic [2:0] DS_N_T2 = 3'd1;
  localparam logic [2:0] DS_V_T = 3'd2;
  localparam logic [2:0] DS_PHI_Q = 3'd3;
  localparam logic [2:0] DS_PROD = 3'd4;
endpackage
`default_nettype wire

// File: hw/rtl/prf_divider.sv
`default_nettype none
// Restoring divider, one quotient bit per cycle, dividend 2*WIDTH bits
module prf_divider (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire logic [2*prf_pkg::WIDTH-1:0] dividend,
  input  wire logic [prf_pkg::WIDTH-1:0] divisor,
  output logic busy,
  output logic [2*prf_pkg::WIDTH-1:0] quotient,
  output logic [prf_pkg::WIDTH-1:0] remainder
);
  localparam int W = prf_pkg::WIDTH;
  localparam int CW = $clog2(2 * W + 1);
  logic [CW-1:0] cnt;
  logic [W:0] rem;
  logic [2*W-1:0] q;
  logic [W-1:0] d;
  logic [W:0] shifted;
  logic [W:0] diff;

  always_comb begin
    shifted = {rem[W-1:0], q[2*W-1]};
    diff = shifted - {1'b0, d};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CW'(2 * W);
      rem <= '0;
      q <= dividend;
      d <= divisor;
    end else if (cnt != '0) begin
      cnt <= cnt - CW'(1);
      if (!diff[W]) begin
        rem <= diff;
        q <= {q[2*W-2:0], 1'b1};
      end else begin
        rem <= shifted;
        q <= {q[2*W-2:0], 1'b0};
      end
    end
  end

  assign busy = (cnt != '0);
  assign quotient = q;
  assign remainder = rem[W-1:0];
endmodule
`default_nettype wire

// File: hw/rtl/prf_datapath.sv
`default_nettype none
// Registers, multiplier and divider for the root search
module prf_datapath (
  input  wire logic clk,
  input  wire logic rst,
  input  wire prf_pkg::cmd_t cmd,
  input  wire logic [prf_pkg::WIDTH-1:0] modulus_in,
  output prf_pkg::sts_t sts,
  output logic [prf_pkg::WIDTH-1:0] r_out
);
  localparam int W = prf_pkg::WIDTH;
  localparam int FW = prf_pkg::FIDX_W;
  localparam int MF = prf_pkg::MAX_FACTORS;

  logic [W-1:0] n, phi, v, r, base, acc;
  logic [W:0] trial;             // trial divisor, may exceed W bits
  logic [W-1:0] ex;
  logic [W-1:0] flist [MF];
  logic [FW-1:0] fcnt, fidx;
  logic p_zero;                  // mod of trial found zero
  logic [2*W-1:0] prod;
  logic ex_mul_acc;              // pending reduction belongs to acc

  logic div_busy;
  logic [2*W-1:0] div_dvd, div_q;
  logic [W-1:0] div_dsr, div_rem;

  logic [2*W+1:0] tsq;
  logic dup;
  logic [W:0] trial2;

  function automatic logic dup_v(input logic [W-1:0] x);
    logic f;
    f = 1'b0;
    for (int k = 0; k < MF; k++) begin
      if (FW'(k) < fcnt && flist[k] == x) f = 1'b1;
    end
    return f;
  endfunction

  always_comb begin
    trial2 = trial + (W+1)'(2);
    div_dvd = {{W{1'b0}}, n};
    div_dsr = trial[W-1:0];
    case (cmd.div_sel)
      prf_pkg::DS_N_T2: div_dsr = trial2[W-1:0];
      prf_pkg::DS_V_T: div_dvd = {{W{1'b0}}, v};
      prf_pkg::DS_PHI_Q: begin
        div_dvd = {{W{1'b0}}, phi};
        div_dsr = flist[fidx[$clog2(MF > 1 ? MF : 2)-1:0]];
      end
      prf_pkg::DS_PROD: begin
        div_dvd = prod;
        div_dsr = n;
      end
      default: ;
    endcase
  end

  prf_divider u_div (
    .clk(clk), .rst(rst), .start(cmd.div_start),
    .dividend(div_dvd), .divisor(div_dsr),
    .busy(div_busy), .quotient(div_q), .remainder(div_rem)
  );

  always_comb begin
    tsq = trial * trial;
    dup = 1'b0;
    for (int k = 0; k < MF; k++) begin
      if (FW'(k) < fcnt && flist[k] == trial[W-1:0]) dup = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) n <= modulus_in;
    case (cmd.op)
      prf_pkg::OP_PINIT: begin
        trial <= (W+1)'(2);
        p_zero <= 1'b0;
      end
      prf_pkg::OP_PMARK: if (div_rem == '0) p_zero <= 1'b1;
      prf_pkg::OP_PSTEP: trial <= (trial == (W+1)'(2)) ? (W+1)'(3) :
                                  (trial == (W+1)'(3)) ? (W+1)'(5) : trial + (W+1)'(6);
      prf_pkg::OP_FINIT: begin
        phi <= n - W'(1);
        v <= n - W'(1);
        trial <= (W+1)'(2);
        fcnt <= '0;
      end
      prf_pkg::OP_FDIVOK: begin
        if (!dup && fcnt < FW'(MF)) begin
          flist[fcnt[$clog2(MF > 1 ? MF : 2)-1:0]] <= trial[W-1:0];
          fcnt <= fcnt + FW'(1);
        end
        v <= div_q[W-1:0];
      end
      prf_pkg::OP_FNEXT: trial <= (trial == (W+1)'(2)) ? (W+1)'(3) : trial2;
      prf_pkg::OP_FLAST: begin
        trial <= {1'b0, v};
        if (v > W'(2) && !(dup_v(v)) && fcnt < FW'(MF)) begin
          flist[fcnt[$clog2(MF > 1 ? MF : 2)-1:0]] <= v;
          fcnt <= fcnt + FW'(1);
        end
      end
      prf_pkg::OP_RINIT: r <= W'(2);
      prf_pkg::OP_RNEXT: r <= r + W'(1);
      prf_pkg::OP_FIDX: fidx <= '0;
      prf_pkg::OP_EINIT: begin
        ex <= div_q[W-1:0];
        base <= r;
        acc <= W'(1);
        fidx <= fidx + FW'(1);
      end
      // registered multiplier feeding the reducing divider
      prf_pkg::OP_EACC: begin
        prod <= acc * base;
        ex_mul_acc <= 1'b1;
      end
      prf_pkg::OP_EBASE: begin
        prod <= base * base;
        ex_mul_acc <= 1'b0;
      end
      // reduced product lands in acc (bit consumed) or base (shift exponent)
      prf_pkg::OP_ERED: begin
        if (ex_mul_acc) begin
          acc <= div_rem;
          ex <= {ex[W-1:1], 1'b0};
        end else begin
          base <= div_rem;
          ex <= ex >> 1;
        end
      end
      default: ;
    endcase
    if (rst) begin
      fcnt <= '0;
      fidx <= '0;
    end
  end

  always_comb begin
    sts.div_busy = div_busy;
    sts.small_n = (n <= W'(3));
    sts.n_le1 = (n <= W'(1));
    sts.rem_zero = (div_rem == '0);
    sts.sq_gt = (tsq > {{(W+2){1'b0}}, (cmd.div_sel == prf_pkg::DS_V_T) ? v : n});
    sts.ex_zero = (ex == '0);
    sts.acc_one = (acc == W'(1));
    sts.r_over = (r > phi);
    sts.f_last = (fidx == fcnt);
    sts.p_mod_zero = p_zero;
    sts.trial2 = (trial == (W+1)'(2));
    sts.ebit = ex[0];
  end

  assign r_out = r;
endmodule
`default_nettype wire

// File: hw/rtl/prf_ctrl.sv
`default_nettype none
// Sequencer for primality test, factoring and root search
module prf_ctrl (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_fire,
  input  wire logic out_free,
  input  wire prf_pkg::sts_t sts,
  output prf_pkg::cmd_t cmd,
  output logic idle,
  output logic done_pulse,
  output logic [1:0] status_code
);
  prf_pkg::state_t state, state_next;
  logic [1:0] code, code_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= prf_pkg::S_IDLE;
      code <= prf_pkg::ST_FOUND;
    end else begin
      state <= state_next;
      code <= code_next;
    end
  end

  always_comb begin
    state_next = state;
    code_next = code;
    cmd = '0;
    done_pulse = 1'b0;
    case (state)
      prf_pkg::S_IDLE: if (in_fire) begin
        cmd.load = 1'b1;
        state_next = prf_pkg::S_PCHK;
      end
      prf_pkg::S_PCHK: begin
        cmd.op = prf_pkg::OP_PINIT;
        if (sts.n_le1) begin
          code_next = prf_pkg::ST_NOT_PRIME;
          state_next = prf_pkg::S_OUT;
        end else if (sts.small_n) state_next = prf_pkg::S_FINIT;
        else state_next = prf_pkg::S_PDIV;
      end
      // trial 2, 3, then 5,11,... with t+2 partner
      prf_pkg::S_PDIV: begin
        cmd.div_sel = prf_pkg::DS_N_T;
        if (sts.p_mod_zero) begin
          code_next = prf_pkg::ST_NOT_PRIME;
          state_next = prf_pkg::S_OUT;
        end else if (!sts.trial2 && sts.sq_gt) state_next = prf_pkg::S_FINIT;
        else begin
          cmd.div_start = 1'b1;
          state_next = prf_pkg::S_PDIV_W;
        end
      end
      prf_pkg::S_PDIV_W: begin
        cmd.div_sel = prf_pkg::DS_N_T;
        if (!sts.div_busy) begin
          cmd.op = prf_pkg::OP_PMARK;
          state_next = prf_pkg::S_PDIV2;
        end
      end
      prf_pkg::S_PDIV2: begin
        cmd.div_sel = prf_pkg::DS_N_T2;
        if (sts.p_mod_zero || sts.trial2) begin
          cmd.op = prf_pkg::OP_PSTEP;
          state_next = prf_pkg::S_PDIV;
        end else begin
          cmd.div_start = 1'b1;
          state_next = prf_pkg::S_PDIV2_W;
        end
      end
      prf_pkg::S_PDIV2_W: begin
        cmd.div_sel = prf_pkg::DS_N_T2;
        if (!sts.div_busy) begin
          cmd.op = prf_pkg::OP_PMARK;
          state_next = prf_pkg::S_FSQ;
        end
      end
      prf_pkg::S_FSQ: begin
        // both t and t+2 tested; move to the next trial pair
        cmd.op = prf_pkg::OP_PSTEP;
        state_next = prf_pkg::S_PDIV;
      end
      prf_pkg::S_FINIT: begin
        cmd.op = prf_pkg::OP_FINIT;
        state_next = prf_pkg::S_FDIV;
      end
      prf_pkg::S_FDIV: begin
        cmd.div_sel = prf_pkg::DS_V_T;
        if (!sts.trial2 && sts.sq_gt) begin
          cmd.op = prf_pkg::OP_FLAST;
          state_next = prf_pkg::S_FADD;
        end else begin
          cmd.div_start = 1'b1;
          state_next = prf_pkg::S_FDIV_W;
        end
      end
      prf_pkg::S_FDIV_W: begin
        cmd.div_sel = prf_pkg::DS_V_T;
        if (!sts.div_busy) begin
          if (sts.rem_zero) begin
            cmd.op = prf_pkg::OP_FDIVOK;
            state_next = prf_pkg::S_FDIV;
          end else begin
            cmd.op = prf_pkg::OP_FNEXT;
            state_next = prf_pkg::S_FDIV;
          end
        end
      end
      prf_pkg::S_FADD: begin
        cmd.op = prf_pkg::OP_RINIT;
        state_next = prf_pkg::S_RNEXT;
      end
      prf_pkg::S_RNEXT: begin
        if (sts.r_over) begin
          code_next = prf_pkg::ST_NO_ROOT;
          state_next = prf_pkg::S_OUT;
        end else begin
          cmd.op = prf_pkg::OP_FIDX;
          state_next = prf_pkg::S_ESTART;
        end
      end
      prf_pkg::S_ESTART: begin
        cmd.div_sel = prf_pkg::DS_PHI_Q;
        if (sts.f_last) begin
          code_next = prf_pkg::ST_FOUND;
          state_next = prf_pkg::S_OUT;
        end else begin
          cmd.div_start = 1'b1;
          state_next = prf_pkg::S_EDIV;
        end
      end
      prf_pkg::S_EDIV: begin
        cmd.div_sel = prf_pkg::DS_PHI_Q;
        if (!sts.div_busy) begin
          cmd.op = prf_pkg::OP_EINIT;
          state_next = prf_pkg::S_EMUL;
        end
      end
      // square and multiply: multiply, then reduce in divider
      prf_pkg::S_EMUL: begin
        if (sts.ex_zero) state_next = prf_pkg::S_ECHK;
        else begin
          cmd.op = sts.ebit ? prf_pkg::OP_EACC : prf_pkg::OP_EBASE;
          state_next = prf_pkg::S_EDIV_W;
        end
      end
      prf_pkg::S_EDIV_W: begin
        cmd.div_sel = prf_pkg::DS_PROD;
        cmd.div_start = 1'b1;
        state_next = prf_pkg::S_EMUL_W;
      end
      prf_pkg::S_EMUL_W: begin
        cmd.div_sel = prf_pkg::DS_PROD;
        if (!sts.div_busy) begin
          // write the reduced product back
          cmd.op = prf_pkg::OP_ERED;
          state_next = prf_pkg::S_EMUL;
        end
      end
      prf_pkg::S_ECHK: begin
        if (sts.acc_one) begin
          cmd.op = prf_pkg::OP_RNEXT;
          state_next = prf_pkg::S_RNEXT;
        end else state_next = prf_pkg::S_ESTART;
      end
      prf_pkg::S_OUT: if (out_free) begin
        done_pulse = 1'b1;
        state_next = prf_pkg::S_IDLE;
      end
      default: state_next = prf_pkg::S_IDLE;
    endcase
  end

  assign idle = (state == prf_pkg::S_IDLE);
  assign status_code = code;
endmodule
`default_nettype wire

// File: hw/rtl/primitive_root_finder_unit.sv
`default_nettype none
// Primitive root finder.
// Input channel: modulus with valid/ready; one transaction per search.
// Output channel: root and status with valid/ready; exactly one result
// transaction per input transaction. Status 0 found, 1 not prime, 2 no root.
// One modulus is processed at a time. Latency depends on the value:
// every trial division and every modular reduction runs through a single
// restoring divider, so the prime test runs two divisions per 6k step,
// factoring one per trial divisor plus one more per factor found, and each
// exponentiation one reduction per clear exponent bit and two per set bit.
// The result sits in an output register; the next modulus is taken as
// soon as the controller returns idle, which happens when the result is
// loaded there. A stalled receiver holds the output register, and once
// the next result is ready it holds the controller as well.
// Synchronous active-high reset returns the controller to idle and
// drops the output valid.
`include "primitive_root_finder_unit_macros.svh"
module primitive_root_finder_unit (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire logic [15:0] modulus,
  output logic out_valid,
  input  wire logic out_ready,
  output logic [15:0] root,
  output logic [1:0] status
);
  prf_pkg::cmd_t cmd;
  prf_pkg::sts_t sts;
  logic idle, done_pulse, in_fire, out_free;
  logic [1:0] code;
  logic [prf_pkg::WIDTH-1:0] r_val;

  assign in_ready = idle;
  assign in_fire = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  prf_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .out_free(out_free), .sts(sts),
    .cmd(cmd), .idle(idle), .done_pulse(done_pulse), .status_code(code)
  );

  prf_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd),
    .modulus_in(modulus), .sts(sts), .r_out(r_val)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done_pulse) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (done_pulse) begin
      status <= code;
      root <= (code == prf_pkg::ST_FOUND) ? 16'(r_val) : 16'd0;
    end
  end

  `PRF_ASSERT_NEXT(a_no_accept_busy, clk, rst, in_fire, !in_ready)
  `PRF_ASSERT_NEXT(a_done_valid, clk, rst, done_pulse, out_valid)
  `PRF_ASSERT_IMPL(a_status_range, clk, rst, out_valid, status != 2'd3)
endmodule
`default_nettype wire

// File: verif/primitive_root_finder_unit_test.sv
module primitive_root_finder_unit_test;

  localparam int WATCHDOG_LIMIT = 2000000;
  localparam int RANDOM_COUNT = 130;

  typedef struct packed {
    logic [15:0] root;
    logic [1:0] status;
  } root_result_t;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic [15:0] modulus;
  logic out_valid;
  logic out_ready;
  logic [15:0] root;
  logic [1:0] status;

  logic [15:0] pending_moduli[$];
  root_result_t expected_roots[$];
  int error_count;
  int idle_cycles;
  int send_wait;
  int recv_wait;
  bit stimulus_done;

  primitive_root_finder_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .modulus(modulus),
    .out_valid(out_valid), .out_ready(out_ready), .root(root), .status(status)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Trial division primality test: 2, 3, then 6k-1 and 6k+1
  function automatic bit check_prime(logic [31:0] n);
    logic [31:0] i;
    if (n <= 1) return 1'b0;
    if (n <= 3) return 1'b1;
    if (n % 2 == 0 || n % 3 == 0) return 1'b0;
    for (i = 5; i * i <= n; i += 6)
      if (n % i == 0 || n % (i + 2) == 0) return 1'b0;
    return 1'b1;
  endfunction

  // Square-and-multiply with double-width products
  function automatic logic [31:0] power_mod(logic [31:0] b, logic [31:0] e,
                                            logic [31:0] m);
    logic [63:0] acc;
    logic [63:0] base;
    acc = 64'(1 % m);
    base = 64'(b % m);
    while (e > 0) begin
      if (e[0]) acc = (acc * base) % m;
      e = e >> 1;
      base = (base * base) % m;
    end
    return acc[31:0];
  endfunction

  // Smallest primitive root of the modulus
  function automatic root_result_t find_root(logic [15:0] m);
    root_result_t res;
    logic [31:0] n, phi, v, i, r;
    logic [31:0] factors[$];
    bit rejected;
    res.root = '0;
    n = 32'(m);
    if (!check_prime(n)) begin
      res.status = prf_pkg::ST_NOT_PRIME;
      return res;
    end
    phi = n - 1;
    v = phi;
    // distinct prime factors of phi, capped at the list capacity
    while (v % 2 == 0) begin
      if (factors.size() == 0) factors.push_back(2);
      v = v / 2;
    end
    for (i = 3; i * i <= v; i += 2) begin
      if (v % i == 0 && factors.size() < prf_pkg::MAX_FACTORS) factors.push_back(i);
      while (v % i == 0) v = v / i;
    end
    if (v > 2 && factors.size() < prf_pkg::MAX_FACTORS) factors.push_back(v);
    for (r = 2; r <= phi; r++) begin
      rejected = 1'b0;
      foreach (factors[k])
        if (!rejected && power_mod(r, phi / factors[k], n) == 1) rejected = 1'b1;
      if (!rejected) begin
        res.root = r[15:0];
        res.status = prf_pkg::ST_FOUND;
        return res;
      end
    end
    res.status = prf_pkg::ST_NO_ROOT;
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    error_count++;
  endtask

  // Stimulus: directed corner values, then mostly primes with some noise
  initial begin
    logic [15:0] m;
    logic [15:0] directed[] = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd7,
                                16'd9, 16'd25, 16'd41, 16'd97, 16'd191, 16'd409,
                                16'd32767, 16'd32768, 16'd65521, 16'd65535,
                                16'd65533, 16'd30031, 16'd65529};
    foreach (directed[k]) pending_moduli.push_back(directed[k]);
    for (int k = 0; k < RANDOM_COUNT; k++) begin
      case ($urandom_range(0, 9))
        0, 1: m = 16'($urandom);
        2: m = 16'($urandom_range(0, 64));
        default: begin
          do m = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(2, 4000));
          while (!check_prime(32'(m)));
        end
      endcase
      pending_moduli.push_back(m);
    end
  end

  // Driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      modulus <= '0;
      send_wait <= $urandom_range(0, 11);
    end else if (in_valid && in_ready) begin
      expected_roots.push_back(find_root(modulus));
      void'(pending_moduli.pop_front());
      in_valid <= 1'b0;
      send_wait <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
    end else if (!in_valid) begin
      if (send_wait > 0) send_wait <= send_wait - 1;
      else if (pending_moduli.size() > 0) begin
        in_valid <= 1'b1;
        modulus <= pending_moduli[0];
      end
    end
  end

  // Monitor and output stall control
  always @(posedge clk) begin
    root_result_t want;
    if (rst) begin
      out_ready <= 1'b0;
      recv_wait <= $urandom_range(0, 11);
    end else begin
      if (out_valid && out_ready) begin
        if (expected_roots.size() == 0) begin
          $display("unexpected result root %0d status %0d at %0t", root, status, $time);
          error_count++;
        end else begin
          want = expected_roots.pop_front();
          if (status !== want.status) report_mismatch("status", 16'(status), 16'(want.status));
          if (root !== want.root) report_mismatch("root", root, want.root);
        end
        out_ready <= 1'b0;
        recv_wait <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
      end else if (!out_ready) begin
        if (recv_wait > 0) recv_wait <= recv_wait - 1;
        else out_ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles with no transaction
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("primitive_root_finder_unit_test: errors");
      $finish;
    end
  end

  initial begin
    error_count = 0;
    idle_cycles = 0;
    rst = 1'b1;
    in_valid = 1'b0;
    modulus = '0;
    out_ready = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (pending_moduli.size() != 0 || in_valid || expected_roots.size() != 0)
      @(posedge clk);
    repeat (100) @(posedge clk);
    if (error_count == 0 && expected_roots.size() == 0)
      $display("primitive_root_finder_unit_test: clean");
    else
      $display("primitive_root_finder_unit_test: errors");
    $finish;
  end

endmodule
